FILE: rtl/sliding_window_median_assert.svh
// Assertion macros for the sliding window median block.
// Used by files that check their own control logic; needs i_clk and i_rst_n in scope.
`ifndef SLIDING_WINDOW_MEDIAN_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SWM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sliding_window_median: check failed");

// antecedent implies consequent in the next cycle
`define SWM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sliding_window_median: check failed");

`endif

FILE: rtl/swm_pkg.sv
// Package for the sliding window median block: word types, cell control, state codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    localparam int SMP_W = 16;
    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic                    sample_invalid;
    } t_in_word;

    typedef struct packed {
        logic signed [SMP_W-1:0] median;
        logic                    median_valid;
        logic                    window_full;
    } t_out_word;

    typedef struct packed {
        logic start;
        logic step;
    } t_cell_ctrl;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_START = 6'b000010,
        ST_STEP  = 6'b000100,
        ST_SEL   = 6'b001000,
        ST_AVG   = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/swm_cell.sv
// One cell of the median chain: holds one sample, passes a circulating word to its
// neighbor and counts the rank of its own sample. Depends on swm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swm_cell #(
    parameter int RW = 4
) (
    input  wire                              i_clk,
    input  wire swm_pkg::t_cell_ctrl         i_ctrl,
    input  wire                              i_ld_new,
    input  wire                              i_ld_nb,
    input  wire                              i_act,
    input  wire signed [swm_pkg::SMP_W-1:0]  i_new_smp,
    input  wire signed [swm_pkg::SMP_W-1:0]  i_nb_smp,
    input  wire signed [swm_pkg::SMP_W-1:0]  i_nb_cv,
    input  wire                              i_nb_cvld,
    input  wire                              i_nb_cwrap,
    input  wire        [RW-1:0]              i_lo_rank,
    input  wire        [RW-1:0]              i_hi_rank,
    output logic signed [swm_pkg::SMP_W-1:0] o_smp,
    output logic signed [swm_pkg::SMP_W-1:0] o_cv,
    output logic                             o_cvld,
    output logic                             o_cwrap,
    output logic                             o_lo_hit,
    output logic                             o_hi_hit
);
    import swm_pkg::*;

    logic signed [SMP_W-1:0] r_smp;
    logic signed [SMP_W-1:0] r_cv;
    logic                    r_cvld;
    logic                    r_cwrap;
    logic [RW-1:0]           r_rank;
    logic                    w_below;

    assign w_below = r_cvld && ((r_cv < r_smp) || ((r_cv == r_smp) && r_cwrap));

    always_ff @(posedge i_clk) begin
        if (i_ld_new) begin
            r_smp <= i_new_smp;
        end else if (i_ld_nb) begin
            r_smp <= i_nb_smp;
        end
        if (i_ctrl.start) begin
            r_cv    <= r_smp;
            r_cvld  <= i_act;
            r_cwrap <= 1'b0;
            r_rank  <= '0;
        end else if (i_ctrl.step) begin
            r_cv    <= i_nb_cv;
            r_cvld  <= i_nb_cvld;
            r_cwrap <= i_nb_cwrap;
            if (w_below) begin
                r_rank <= r_rank + 1'b1;
            end
        end
    end

    assign o_smp    = r_smp;
    assign o_cv     = r_cv;
    assign o_cvld   = r_cvld;
    assign o_cwrap  = r_cwrap;
    assign o_lo_hit = i_act && (r_rank == i_lo_rank);
    assign o_hi_hit = i_act && (r_rank == i_hi_rank);

endmodule

`default_nettype wire

FILE: rtl/sliding_window_median.sv
// Sliding window median filter, top level: control sequencer and a ring of swm_cell.
// Depends on swm_pkg, swm_cell and sliding_window_median_assert.svh.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one word (sample, sample_invalid).
//   Output channel: o_out_valid / i_out_stall carry one word (median, median_valid,
//   window_full). Every input word gives exactly one output word, in order.
//   Config: i_cfg_we writes window_size from i_cfg_wdata and empties the window;
//   write only while the block is idle. Zero acts as 1, values above MAX_WINDOW
//   saturate.
//   Sequence: a valid sample passes through ST_START, ST_STEP, ST_SEL, ST_AVG and
//   ST_DONE to the output register, an invalid one only through ST_DONE. One word
//   is processed at a time, so the next is accepted only after ST_DONE; ST_STEP is
//   the rank count, where the held samples rotate once around the cell ring.
//   Reset: window_size 16, no samples held, median 0, median_valid 0.
//   Stall: the finished word holds in the output register while i_out_stall is
//   high; the next input word is still accepted and computed, and waits for the
//   output register before it is handed over.
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_median_assert.svh"

module sliding_window_median #(
    parameter int MAX_WINDOW = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    input  wire swm_pkg::t_in_word       i_in_word,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    output swm_pkg::t_out_word           o_out_word,
    input  wire                          i_out_stall,
    input  wire                          i_cfg_we,
    input  wire  [swm_pkg::CFG_W-1:0]    i_cfg_wdata
);
    import swm_pkg::*;

    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int RW = $clog2(MAX_WINDOW);

    t_state                  r_state, n_state;
    logic [CFG_W-1:0]        r_wsz;
    logic [CW-1:0]           r_held;
    logic [RW-1:0]           r_cnt;
    logic signed [SMP_W-1:0] r_med;
    logic                    r_seen;
    logic signed [SMP_W-1:0] r_sel_lo;
    logic signed [SMP_W-1:0] r_sel_hi;
    logic                    r_ovld;
    t_out_word               r_oword;

    logic [CW-1:0]           w_win;
    logic                    w_acc;
    logic                    w_take;
    logic                    w_full;
    logic                    w_last_step;
    logic                    w_emit;
    logic [RW-1:0]           w_lo_rank;
    logic [RW-1:0]           w_hi_rank;
    t_cell_ctrl              w_ctrl;
    logic signed [SMP_W-1:0] w_lo_val;
    logic signed [SMP_W-1:0] w_hi_val;
    logic signed [SMP_W:0]   w_sum;

    logic signed [SMP_W-1:0] w_smp  [MAX_WINDOW];
    logic signed [SMP_W-1:0] w_cv   [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]   w_cvld;
    logic [MAX_WINDOW-1:0]   w_cwrap;
    logic [MAX_WINDOW-1:0]   w_hit_lo;
    logic [MAX_WINDOW-1:0]   w_hit_hi;

    always_comb begin
        if (r_wsz == '0) begin
            w_win = CW'(1);
        end else if (int'(r_wsz) > MAX_WINDOW) begin
            w_win = CW'(MAX_WINDOW);
        end else begin
            w_win = CW'(r_wsz);
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_acc       = i_in_valid && !o_in_stall;
    assign w_take      = w_acc && !i_in_word.sample_invalid;
    assign w_full      = (r_held >= w_win);
    assign w_last_step = (r_cnt == RW'(MAX_WINDOW - 1));
    assign w_emit      = (r_state == ST_DONE) && (!r_ovld || !i_out_stall);

    assign w_hi_rank = RW'(r_held >> 1);
    assign w_lo_rank = r_held[0] ? RW'(r_held >> 1) : RW'((r_held >> 1) - 1'b1);

    assign w_ctrl.start = (r_state == ST_START);
    assign w_ctrl.step  = (r_state == ST_STEP);

    for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
        localparam int NB = (k + 1) % MAX_WINDOW;
        logic w_ld_new;
        logic w_ld_nb;

        assign w_ld_new = w_take && (w_full ? (CW'(k) == w_win - 1'b1) : (CW'(k) == r_held));
        assign w_ld_nb  = w_take && w_full && (CW'(k) < w_win - 1'b1);

        swm_cell #(
            .RW (RW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_ld_new   (w_ld_new),
            .i_ld_nb    (w_ld_nb),
            .i_act      (CW'(k) < r_held),
            .i_new_smp  (i_in_word.sample),
            .i_nb_smp   (w_smp[NB]),
            .i_nb_cv    (w_cv[NB]),
            .i_nb_cvld  (w_cvld[NB]),
            .i_nb_cwrap ((k == MAX_WINDOW - 1) ? 1'b1 : w_cwrap[NB]),
            .i_lo_rank  (w_lo_rank),
            .i_hi_rank  (w_hi_rank),
            .o_smp      (w_smp[k]),
            .o_cv       (w_cv[k]),
            .o_cvld     (w_cvld[k]),
            .o_cwrap    (w_cwrap[k]),
            .o_lo_hit   (w_hit_lo[k]),
            .o_hi_hit   (w_hit_hi[k])
        );
    end

    always_comb begin
        w_lo_val = '0;
        w_hi_val = '0;
        for (int k = 0; k < MAX_WINDOW; k++) begin
            w_lo_val = w_lo_val | (w_hit_lo[k] ? w_smp[k] : '0);
            w_hi_val = w_hi_val | (w_hit_hi[k] ? w_smp[k] : '0);
        end
    end

    assign w_sum = {r_sel_lo[SMP_W-1], r_sel_lo} + {r_sel_hi[SMP_W-1], r_sel_hi};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_state = i_in_word.sample_invalid ? ST_DONE : ST_START;
                end
            end
            ST_START: n_state = ST_STEP;
            ST_STEP: begin
                if (w_last_step) begin
                    n_state = ST_SEL;
                end
            end
            ST_SEL:  n_state = ST_AVG;
            ST_AVG:  n_state = ST_DONE;
            ST_DONE: begin
                if (w_emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wsz   <= CFG_RESET;
            r_held  <= '0;
            r_cnt   <= '0;
            r_med   <= '0;
            r_seen  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_wsz  <= i_cfg_wdata;
                r_held <= '0;
            end else if (w_take && !w_full) begin
                r_held <= r_held + 1'b1;
            end
            if (w_ctrl.start) begin
                r_cnt <= '0;
            end else if (w_ctrl.step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == ST_AVG) begin
                r_med  <= w_sum[SMP_W:1];
                r_seen <= 1'b1;
            end
            if (w_emit) begin
                r_ovld <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SEL) begin
            r_sel_lo <= w_lo_val;
            r_sel_hi <= w_hi_val;
        end
        if (w_emit) begin
            r_oword.median       <= r_med;
            r_oword.median_valid <= r_seen;
            r_oword.window_full  <= w_full;
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out_word  = r_oword;

    `SWM_ASSERT_NXT(a_take_starts, w_take, r_state == ST_START)
    `SWM_ASSERT_IMP(a_held_in_win, 1'b1, r_held <= w_win)
    `SWM_ASSERT_IMP(a_one_hi_hit, r_state == ST_SEL, $countones(w_hit_hi) == 1)
    `SWM_ASSERT_IMP(a_one_lo_hit, r_state == ST_SEL, $countones(w_hit_lo) == 1)
    `SWM_ASSERT_IMP(a_seen_sticky, 1'b1, !$fell(r_seen))

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Testbench for sliding_window_median: predicts every output word from the accepted input words
// and checks them in order, over several window sizes and with random idling on both sides.
// Depends on swm_pkg and the sliding_window_median RTL.
`timescale 1ns / 1ps

module tb;
    import swm_pkg::*;

    localparam int MAX_WIN    = 16;
    localparam int IDLE_LIMIT = 2000;
    localparam int N_DIRECTED = 22;
    localparam int N_PHASES   = 10;
    localparam int PHASE_LEN  = 60;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    t_in_word            i_in_word = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    t_out_word           o_out_word;
    logic                i_out_stall = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CFG_W-1:0]    i_cfg_wdata = '0;

    sliding_window_median #(
        .MAX_WINDOW (MAX_WIN)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // filter state as seen from outside
    logic [CFG_W-1:0]    window_reg = CFG_RESET;
    logic signed [15:0]  held_samples[MAX_WIN];
    int                  held_count = 0;
    logic signed [15:0]  last_median = '0;
    logic                median_seen = 1'b0;

    t_in_word            pending_words[$];
    t_out_word           expected_medians[$];
    int                  words_queued = 0;
    int                  results_seen = 0;
    int                  errors = 0;
    logic                in_fire = 1'b0;

    int dir_sample[N_DIRECTED] = '{32'h1234, -32768, 32767, 32767, -32768, -32768, -3, 32767,
                                   -2, 0, 1, 100, -100, 5, 5, 5, -7, 2, 32767, -32768, 9, -1};
    bit dir_invalid[N_DIRECTED] = '{1, 1, 0, 0, 0, 0, 0, 1, 0, 0, 0,
                                    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    logic [CFG_W-1:0] phase_windows[N_PHASES] = '{5'd1, 5'd0, 5'd2, 5'd31, 5'd3,
                                                  5'd17, 5'd16, 5'd5, 5'd8, 5'd4};

    function automatic t_out_word next_median_word(t_in_word w);
        int        win;
        int        sorted_vals[MAX_WIN];
        int        i;
        int        j;
        int        v;
        int        sum;
        t_out_word r;
        win = (window_reg == 0) ? 1 : ((window_reg > MAX_WIN) ? MAX_WIN : int'(window_reg));
        if (!w.sample_invalid) begin
            if (held_count < win) begin
                held_samples[held_count] = w.sample;
                held_count++;
            end else begin
                for (i = 1; i < win; i++)
                    held_samples[i-1] = held_samples[i];
                held_samples[win-1] = w.sample;
                held_count = win;
            end
            for (i = 0; i < held_count; i++) begin
                v = int'(held_samples[i]);
                j = i;
                while (j > 0 && sorted_vals[j-1] > v) begin
                    sorted_vals[j] = sorted_vals[j-1];
                    j--;
                end
                sorted_vals[j] = v;
            end
            if (held_count % 2 == 1) begin
                last_median = 16'(sorted_vals[held_count/2]);
            end else begin
                sum = sorted_vals[held_count/2 - 1] + sorted_vals[held_count/2];
                last_median = 16'(sum >>> 1);
            end
            median_seen = 1'b1;
        end
        r.median       = last_median;
        r.median_valid = median_seen;
        r.window_full  = (held_count >= win);
        return r;
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        int       k;
        w.sample_invalid = ($urandom_range(0, 7) == 0);
        case ($urandom_range(0, 9))
            0: w.sample = 16'sh7FFF;
            1: w.sample = 16'sh8000;
            2, 3: begin
                k = $urandom_range(0, 8);
                w.sample = 16'(k - 4);
            end
            default: w.sample = 16'($urandom);
        endcase
        return w;
    endfunction

    task automatic queue_word(t_in_word w);
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic wait_all_done();
        while (results_seen != words_queued)
            @(negedge i_clk);
    endtask

    task automatic report_field(string field, int want, int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $realtime, field, want, got);
            errors++;
        end
    endtask

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // input driver: bursts of words with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                i_in_word  <= pending_words.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 40);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output stall pattern, with one long hold while the sender keeps offering
    int  stall_mode = 0;
    int  mode_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(negedge i_clk) begin
        if (!hold_done && results_seen >= 200 && pending_words.size() > 20) begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(5, 60);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 1) == 0);
                default: i_out_stall <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // monitor: predict on every accepted input word, check every accepted output word
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_medians.size() == 0) begin
                    $display("%0t: unexpected word, actual median %0d valid %0b full %0b",
                             $realtime, o_out_word.median, o_out_word.median_valid,
                             o_out_word.window_full);
                    errors++;
                end else begin
                    want = expected_medians.pop_front();
                    report_field("median", int'(want.median), int'(o_out_word.median));
                    report_field("median_valid", int'(want.median_valid),
                                 int'(o_out_word.median_valid));
                    report_field("window_full", int'(want.window_full),
                                 int'(o_out_word.window_full));
                end
            end
            if (i_in_valid && !o_in_stall)
                expected_medians.push_back(next_median_word(i_in_word));
        end
        in_fire <= i_rst_n && i_in_valid && !o_in_stall;
    end

    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $realtime, IDLE_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        t_in_word w;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            w.sample         = 16'(dir_sample[i]);
            w.sample_invalid = dir_invalid[i];
            queue_word(w);
        end
        for (int i = 0; i < 50; i++)
            queue_word(random_word());

        for (int p = 0; p < N_PHASES; p++) begin
            wait_all_done();
            repeat (3) @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= phase_windows[p];
            window_reg = phase_windows[p];
            held_count = 0;
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            for (int i = 0; i < PHASE_LEN; i++)
                queue_word(random_word());
        end

        wait_all_done();
        repeat (MAX_WIN + 8) @(negedge i_clk);
        if (expected_medians.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $realtime, expected_medians.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
